FILE: src/kwh_pkg.sv
package kwh_pkg;

    localparam int unsigned HASH_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_FIRST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_SECOND    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_THIRD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_CODES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CODES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LETTER_CLASSES = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_SELECT   = 3'd7;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_Z     = 8'h7a;

    localparam logic [1:0] ROUND_FIRST  = 2'd0;
    localparam logic [1:0] ROUND_SECOND = 2'd1;
    localparam logic [1:0] ROUND_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       word_end;
    } kwh_in_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        bad_char_seen;
    } kwh_out_t;

    typedef struct packed {
        logic [63:0] start_value;
        logic [63:0] mult_first;
        logic [63:0] mult_second;
        logic [63:0] mult_third;
        logic [23:0] class_codes;
        logic [59:0] digit_codes;
        logic [51:0] letter_classes;
        logic [5:0]  shift_select;
    } kwh_cfg_t;

    typedef struct packed {
        logic       load_in;
        logic       do_xor;
        logic       do_mul0;
        logic       do_mul1;
        logic       do_mul2;
        logic       do_add;
        logic       load_out;
        logic [1:0] round;
    } kwh_cmd_t;

    typedef struct packed {
        logic mix_in;
        logic last;
    } kwh_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XOR,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_ADD,
        ST_DONE
    } kwh_state_t;

endpackage

FILE: src/kwh_cfg.sv
module kwh_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [kwh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kwh_pkg::CFG_DAT_W-1:0]     cfg_data,
    output kwh_pkg::kwh_cfg_t                 regs
);

    kwh_pkg::kwh_cfg_t regs_reg;
    kwh_pkg::kwh_cfg_t regs_next;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                kwh_pkg::CFG_START_VALUE:    regs_next.start_value    = cfg_data;
                kwh_pkg::CFG_MULT_FIRST:     regs_next.mult_first     = cfg_data;
                kwh_pkg::CFG_MULT_SECOND:    regs_next.mult_second    = cfg_data;
                kwh_pkg::CFG_MULT_THIRD:     regs_next.mult_third     = cfg_data;
                kwh_pkg::CFG_CLASS_CODES:    regs_next.class_codes    = cfg_data[23:0];
                kwh_pkg::CFG_DIGIT_CODES:    regs_next.digit_codes    = cfg_data[59:0];
                kwh_pkg::CFG_LETTER_CLASSES: regs_next.letter_classes = cfg_data[51:0];
                kwh_pkg::CFG_SHIFT_SELECT:   regs_next.shift_select   = cfg_data[5:0];
                default:                     regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

FILE: src/kwh_ctrl.sv
module kwh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    output logic                hash_valid,
    input  logic                hash_ready,
    input  kwh_pkg::kwh_stat_t  stat,
    output kwh_pkg::kwh_cmd_t   cmd
);

    kwh_pkg::kwh_state_t state_reg;
    kwh_pkg::kwh_state_t state_next;
    logic [1:0]          round_reg;
    logic [1:0]          round_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kwh_pkg::ST_IDLE;
            round_reg     <= kwh_pkg::ROUND_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !hash_ready;
        cmd            = '0;
        cmd.round      = round_reg;
        char_ready     = 1'b0;

        case (state_reg)
            kwh_pkg::ST_IDLE:
            begin
                char_ready = 1'b1;
                if (char_valid)
                begin
                    cmd.load_in = 1'b1;
                    round_next  = kwh_pkg::ROUND_FIRST;
                    state_next  = stat.mix_in ? kwh_pkg::ST_XOR : kwh_pkg::ST_DONE;
                end
            end
            kwh_pkg::ST_XOR:
            begin
                cmd.do_xor = 1'b1;
                state_next = kwh_pkg::ST_MUL0;
            end
            kwh_pkg::ST_MUL0:
            begin
                cmd.do_mul0 = 1'b1;
                state_next  = kwh_pkg::ST_MUL1;
            end
            kwh_pkg::ST_MUL1:
            begin
                cmd.do_mul1 = 1'b1;
                state_next  = kwh_pkg::ST_MUL2;
            end
            kwh_pkg::ST_MUL2:
            begin
                cmd.do_mul2 = 1'b1;
                if (round_reg == kwh_pkg::ROUND_THIRD)
                begin
                    state_next = kwh_pkg::ST_ADD;
                end
                else
                begin
                    round_next = round_reg + 2'd1;
                    state_next = kwh_pkg::ST_XOR;
                end
            end
            kwh_pkg::ST_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = kwh_pkg::ST_DONE;
            end
            kwh_pkg::ST_DONE:
            begin
                if (!stat.last)
                begin
                    state_next = kwh_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || hash_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = kwh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwh_pkg::ST_IDLE;
            end
        endcase
    end

    assign hash_valid = out_valid_reg;

endmodule

FILE: src/kwh_dp.sv
module kwh_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  kwh_pkg::kwh_in_t    char_data,
    input  kwh_pkg::kwh_cfg_t   regs,
    input  kwh_pkg::kwh_cmd_t   cmd,
    output kwh_pkg::kwh_stat_t  stat,
    output kwh_pkg::kwh_out_t   hash_data
);

    logic [kwh_pkg::HASH_W-1:0] h_reg;
    logic [kwh_pkg::HASH_W-1:0] h_next;
    logic [kwh_pkg::HASH_W-1:0] acc_reg;
    logic [kwh_pkg::HASH_W-1:0] acc_next;
    logic [kwh_pkg::CODE_W-1:0] code_reg;
    logic [kwh_pkg::CODE_W-1:0] code_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       bad_reg;
    logic                       bad_next;
    logic                       fresh_reg;
    logic                       fresh_next;
    kwh_pkg::kwh_out_t          out_reg;
    kwh_pkg::kwh_out_t          out_next;

    logic [7:0]                 ch;
    logic                       is_space;
    logic                       is_digit;
    logic                       is_letter;
    logic [3:0]                 digit;
    logic [5:0]                 digit_base;
    logic [4:0]                 letter;
    logic [1:0]                 letter_class;
    logic [kwh_pkg::CODE_W-1:0] code_in;

    logic [kwh_pkg::HASH_W-1:0] mult;
    logic [1:0]                 shift_sel;
    logic [5:0]                 shift_amt;
    logic [kwh_pkg::HALF_W-1:0] op_a;
    logic [kwh_pkg::HALF_W-1:0] op_b;
    logic [kwh_pkg::HASH_W-1:0] prod;

    always_comb
    begin
        ch           = char_data.char_byte;
        is_space     = (ch == kwh_pkg::CHAR_SPACE);
        is_digit     = (ch inside {[kwh_pkg::CHAR_ZERO:kwh_pkg::CHAR_NINE]});
        is_letter    = (ch inside {[kwh_pkg::CHAR_A:kwh_pkg::CHAR_Z]});
        digit        = ch[3:0];
        digit_base   = 6'(digit) * 6'd6;
        letter       = 5'(ch - kwh_pkg::CHAR_A);
        letter_class = regs.letter_classes[{letter, 1'b0} +: 2];
        code_in      = '0;
        if (is_digit)
        begin
            code_in = {2'b00, regs.digit_codes[digit_base +: 6]};
        end
        else if (is_letter)
        begin
            case (letter_class)
                2'd0:    code_in = regs.class_codes[7:0];
                2'd1:    code_in = regs.class_codes[15:8];
                2'd2:    code_in = regs.class_codes[23:16];
                default: code_in = '0;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.round)
            kwh_pkg::ROUND_FIRST:
            begin
                mult      = regs.mult_first;
                shift_sel = regs.shift_select[1:0];
            end
            kwh_pkg::ROUND_SECOND:
            begin
                mult      = regs.mult_second;
                shift_sel = regs.shift_select[3:2];
            end
            default:
            begin
                mult      = regs.mult_third;
                shift_sel = regs.shift_select[5:4];
            end
        endcase
        shift_amt = {shift_sel, 4'b0001};
    end

    // shared 32x32 multiplier: one partial product of the low 64 bits per cycle
    always_comb
    begin
        if (cmd.do_mul0)
        begin
            op_a = h_reg[31:0];
            op_b = mult[31:0];
        end
        else if (cmd.do_mul1)
        begin
            op_a = h_reg[31:0];
            op_b = mult[63:32];
        end
        else
        begin
            op_a = h_reg[63:32];
            op_b = mult[31:0];
        end
        prod = {32'd0, op_a} * {32'd0, op_b};
    end

    always_comb
    begin
        h_next     = h_reg;
        acc_next   = acc_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;
        fresh_next = fresh_reg;
        out_next   = out_reg;

        if (cmd.load_in)
        begin
            code_next  = code_in;
            last_next  = char_data.word_end;
            fresh_next = 1'b0;
            if (fresh_reg)
            begin
                h_next   = regs.start_value;
                bad_next = !(is_space || is_digit || is_letter);
            end
            else
            begin
                bad_next = bad_reg || !(is_space || is_digit || is_letter);
            end
        end

        if (cmd.do_xor)
        begin
            h_next = h_reg ^ (h_reg >> shift_amt);
        end

        if (cmd.do_mul0)
        begin
            acc_next = prod;
        end

        if (cmd.do_mul1)
        begin
            acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
        end

        if (cmd.do_mul2)
        begin
            h_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
        end

        if (cmd.do_add)
        begin
            h_next = h_reg + {56'd0, code_reg};
        end

        if (cmd.load_out)
        begin
            out_next.hash_value    = h_reg;
            out_next.bad_char_seen = bad_reg;
            fresh_next             = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg     <= '0;
            bad_reg   <= 1'b0;
            fresh_reg <= 1'b1;
            last_reg  <= 1'b0;
        end
        else
        begin
            h_reg     <= h_next;
            bad_reg   <= bad_next;
            fresh_reg <= fresh_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        code_reg <= code_next;
        out_reg  <= out_next;
    end

    assign stat.mix_in = is_digit || is_letter;
    assign stat.last   = last_reg;
    assign hash_data   = out_reg;

endmodule

FILE: src/keyword_string_hash_top.sv
// channel  | valid      | ready      | payload
// ---------+------------+------------+------------------------------------
// char     | char_valid | char_ready | char_data (char_byte, word_end)
// hash     | hash_valid | hash_ready | hash_data (hash_value, bad_char_seen)
// cfg      | cfg_valid  | cfg_ready  | cfg_index, cfg_data
//
// A letter or digit passes through acceptance, three rounds (xorshift, then
// three 32x32 partial products on the one shared multiplier), the code add
// and a finishing step. A space or other byte is accepted and then finished.
// Reset clears the configuration registers, the running hash and all handshake state.
// A finished hash waits in the output register; the next characters are
// still taken, and a second word end holds until that result leaves.
// cfg_ready is always high.
module keyword_string_hash_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              char_valid,
    output logic                              char_ready,
    input  kwh_pkg::kwh_in_t                  char_data,
    output logic                              hash_valid,
    input  logic                              hash_ready,
    output kwh_pkg::kwh_out_t                 hash_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kwh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kwh_pkg::CFG_DAT_W-1:0]     cfg_data
);

    kwh_pkg::kwh_cfg_t  regs;
    kwh_pkg::kwh_cmd_t  cmd;
    kwh_pkg::kwh_stat_t stat;

    assign cfg_ready = 1'b1;

    kwh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    kwh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    kwh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_data (char_data),
        .regs      (regs),
        .cmd       (cmd),
        .stat      (stat),
        .hash_data (hash_data)
    );

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.do_xor, cmd.do_mul0, cmd.do_mul1,
                  cmd.do_mul2, cmd.do_add, cmd.load_out}))
        else $error("more than one datapath step in a cycle");

    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_mul0 |=> cmd.do_mul1 ##1 cmd.do_mul2)
        else $error("partial products out of order");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_ready |=> !char_ready)
        else $error("character taken while previous one in progress");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> hash_valid)
        else $error("loaded result not presented");

endmodule

FILE: sim/word_hash_check_pkg.sv
package word_hash_check_pkg;

    import kwh_pkg::*;

    class word_hash_tracker;
        kwh_cfg_t    regs;
        logic [63:0] running;
        bit          fresh;
        bit          bad_seen;
        kwh_out_t    pending[$];
        int          mismatches;
        int          chars_noted;
        int          hashes_checked;
        int          writes_noted;

        function new();
            regs           = '0;
            running        = '0;
            fresh          = 1'b1;
            bad_seen       = 1'b0;
            mismatches     = 0;
            chars_noted    = 0;
            hashes_checked = 0;
            writes_noted   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            writes_noted++;
            case (idx)
                CFG_START_VALUE:    regs.start_value    = value;
                CFG_MULT_FIRST:     regs.mult_first     = value;
                CFG_MULT_SECOND:    regs.mult_second    = value;
                CFG_MULT_THIRD:     regs.mult_third     = value;
                CFG_CLASS_CODES:    regs.class_codes    = value[23:0];
                CFG_DIGIT_CODES:    regs.digit_codes    = value[59:0];
                CFG_LETTER_CLASSES: regs.letter_classes = value[51:0];
                CFG_SHIFT_SELECT:   regs.shift_select   = value[5:0];
                default:            ;
            endcase
        endfunction

        function logic [63:0] mix_rounds(logic [63:0] h);
            logic [63:0] mults [3];
            logic [1:0]  sel;
            mults[0] = regs.mult_first;
            mults[1] = regs.mult_second;
            mults[2] = regs.mult_third;
            for (int r = 0; r < 3; r++)
            begin
                sel = regs.shift_select[2*r +: 2];
                h   = h ^ (h >> (1 + 16 * sel));
                h   = h * mults[r];
            end
            return h;
        endfunction

        function void note_char(kwh_in_t item);
            logic [7:0] ch;
            logic [7:0] code;
            logic [1:0] cls;
            int         idx;
            bit         mapped;
            kwh_out_t   result;
            ch = item.char_byte;
            chars_noted++;
            if (fresh)
            begin
                running  = regs.start_value;
                bad_seen = 1'b0;
                fresh    = 1'b0;
            end
            mapped = 1'b1;
            code   = '0;
            if (ch == CHAR_SPACE)
            begin
                mapped = 1'b0;
            end
            else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                idx  = ch - CHAR_ZERO;
                code = {2'b00, regs.digit_codes[6*idx +: 6]};
            end
            else if (ch >= CHAR_A && ch <= CHAR_Z)
            begin
                idx  = ch - CHAR_A;
                cls  = regs.letter_classes[2*idx +: 2];
                code = (cls == 2'd3) ? 8'd0 : regs.class_codes[8*cls +: 8];
            end
            else
            begin
                mapped   = 1'b0;
                bad_seen = 1'b1;
            end
            if (mapped)
                running = mix_rounds(running) + {56'd0, code};
            if (item.word_end)
            begin
                result.hash_value    = running;
                result.bad_char_seen = bad_seen;
                pending = {pending, result};
                fresh = 1'b1;
            end
        endfunction

        function void check_hash(kwh_out_t got);
            kwh_out_t want;
            if (pending.size() == 0)
            begin
                $error("hash transaction with no word outstanding: hash_value=%h",
                       got.hash_value);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            hashes_checked++;
            if (got.hash_value !== want.hash_value)
            begin
                $error("hash_value: expected %h, got %h", want.hash_value, got.hash_value);
                mismatches++;
            end
            if (got.bad_char_seen !== want.bad_char_seen)
            begin
                $error("bad_char_seen: expected %b, got %b",
                       want.bad_char_seen, got.bad_char_seen);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: sim/tb_keyword_string_hash_top.sv
module tb_keyword_string_hash_top;

    timeunit 1ns;
    timeprecision 1ps;

    import kwh_pkg::*;
    import word_hash_check_pkg::*;

    localparam int  IDLE_CYCLES     = 40;
    localparam int  HOLD_CYCLES     = 400;
    localparam int  ITEMS_PER_PHASE = 100;
    localparam int  NUM_PHASES      = 6;
    localparam real LIMIT_NS        = 5_000_000.0;

    logic                 clk;
    logic                 rst_n;
    logic                 char_valid;
    logic                 char_ready;
    kwh_in_t              char_data;
    logic                 hash_valid;
    logic                 hash_ready;
    kwh_out_t             hash_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    word_hash_tracker tracker;
    int               idle_mode = 1;
    bit               hold_req  = 1'b0;
    int               settings_used = 0;

    keyword_string_hash_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash_data  (hash_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("FAIL keyword_string_hash_top");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CHAR_A + 8'($urandom_range(0, 25));
        if (r < 85)
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        return CHAR_SPACE;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid          <= 1'b1;
        char_data.char_byte <= ch;
        char_data.word_end  <= last;
        do
            @(posedge clk);
        while (!char_ready);
        tracker.note_char('{char_byte: ch, word_end: last});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, value);
    endtask

    task automatic write_settings(input logic [63:0] start, input logic [63:0] m1,
                                  input logic [63:0] m2, input logic [63:0] m3,
                                  input logic [63:0] cc, input logic [63:0] dc,
                                  input logic [63:0] lc, input logic [63:0] ss);
        write_reg(CFG_START_VALUE, start);
        write_reg(CFG_MULT_FIRST, m1);
        write_reg(CFG_MULT_SECOND, m2);
        write_reg(CFG_MULT_THIRD, m3);
        write_reg(CFG_CLASS_CODES, cc);
        write_reg(CFG_DIGIT_CODES, dc);
        write_reg(CFG_LETTER_CLASSES, lc);
        write_reg(CFG_SHIFT_SELECT, ss);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic write_random_settings();
        write_settings(rand64(), rand64(), rand64(), rand64(),
                       rand64(), rand64(), rand64(), rand64());
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        // force letter q into class three
        write_settings(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                       rand64() | (64'd3 << (2 * 16)), rand64());
        send_char(CHAR_A, 1'b1);
        send_char(CHAR_Z, 1'b1);
        send_char(CHAR_ZERO, 1'b0);
        send_char(CHAR_NINE, 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        send_char(CHAR_A + 8'd16, 1'b1);
        send_char(8'hff, 1'b0);
        send_char(CHAR_A + 8'd12, 1'b1);
        send_char(CHAR_SPACE, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(CHAR_SPACE, 1'b1);
        send_char(8'h80, 1'b1);
        send_char(CHAR_ZERO - 8'd1, 1'b0);
        send_char(CHAR_NINE + 8'd1, 1'b0);
        send_char(CHAR_A - 8'd1, 1'b0);
        send_char(CHAR_Z + 8'd1, 1'b0);
        send_char(CHAR_SPACE - 8'd1, 1'b0);
        send_char(CHAR_SPACE + 8'd1, 1'b0);
        send_char(CHAR_ZERO + 8'd5, 1'b1);
        // change every register part way through a word
        send_char(CHAR_A + 8'd1, 1'b0);
        send_char(CHAR_ZERO + 8'd7, 1'b0);
        settle();
        write_random_settings();
        send_char(CHAR_A + 8'd2, 1'b1);
        send_char(CHAR_A + 8'd10, 1'b1);
    endtask

    task automatic run_phase(input bit pause_midway);
        int sent;
        int len;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < ITEMS_PER_PHASE)
        begin
            if (pause_midway && !paused && sent >= ITEMS_PER_PHASE / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    send_char(random_char(), i == len - 1);
                sent += len;
            end
            else
            begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
        send_char(random_char(), 1'b1);
    endtask

    initial
    begin
        int gap;
        hash_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hash_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                hash_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            hash_ready <= 1'b1;
            @(posedge clk);
            if (hash_valid)
                tracker.check_hash(hash_data);
        end
    end

    initial
    begin
        tracker = new();
        rst_n      <= 1'b0;
        char_valid <= 1'b0;
        char_data  <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0:       write_settings('0, '0, '0, '0, '0, '0, '0, '0);
                1:       write_settings('1, '1, '1, '1, '1, '1, '1, '1);
                default: write_random_settings();
            endcase
            idle_mode = (p == 1) ? 0 : 1;
            // stall the result side long enough to back up the character side
            if (p == 2)
                hold_req = 1'b1;
            run_phase(p == 3);
        end

        settle();
        if (tracker.pending.size() != 0)
        begin
            $error("%0d hash transactions never arrived", tracker.pending.size());
            tracker.mismatches++;
        end
        $display("Summary: %0d characters sent, %0d word hashes checked,",
                 tracker.chars_noted, tracker.hashes_checked);
        $display("  %0d register writes over %0d settings incl. all-zero and all-one",
                 tracker.writes_noted, settings_used);
        if (tracker.mismatches == 0)
            $display("PASS keyword_string_hash_top");
        else
            $display("FAIL keyword_string_hash_top");
        $finish;
    end

endmodule

FILE: keyword_string_hash_top.f
src/kwh_pkg.sv
src/kwh_cfg.sv
src/kwh_ctrl.sv
src/kwh_dp.sv
src/keyword_string_hash_top.sv
sim/word_hash_check_pkg.sv
sim/tb_keyword_string_hash_top.sv
